>>> hw/rtl/rbs_pkg.sv
package rbs_pkg;

  // Task priorities. Lower number means higher priority.
  localparam int NUM_PRIOS   = 32;
  localparam int IDLE_PRIO   = 31;
  localparam int SLEEP_WIDTH = 16;

  // Field widths fixed by the interface.
  localparam int PRIO_W  = 5;
  localparam int FUNC_W  = 3;
  localparam int MASK_W  = 32;
  localparam int NEST_W  = 8;
  localparam int STK_W   = 16;

  // Index width into the per-task stores.
  localparam int IDX_W = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;

  localparam logic [MASK_W-1:0] PRIO_MASK = MASK_W'((64'd1 << NUM_PRIOS) - 64'd1);
  localparam logic [PRIO_W:0]   NUM_PRIOS_CMP = (PRIO_W + 1)'(NUM_PRIOS);
  localparam logic [PRIO_W-1:0] IDLE_PRIO_V   = PRIO_W'(IDLE_PRIO);
  localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(NUM_PRIOS - 1);

  // Byte lanes of the ready bitmap, scanned from the low end.
  localparam logic [MASK_W-1:0] BYTE0_MASK = 32'h0000_00ff;
  localparam logic [MASK_W-1:0] BYTE1_MASK = 32'h0000_ff00;
  localparam logic [MASK_W-1:0] BYTE2_MASK = 32'h00ff_0000;
  localparam logic [MASK_W-1:0] BYTE3_MASK = 32'hff00_0000;

  // Command codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_READY_ADD = 3'd0,
    FUNC_READY_DEL = 3'd1,
    FUNC_TICK      = 3'd2,
    FUNC_IRQ_ENTER = 3'd3,
    FUNC_IRQ_LEAVE = 3'd4,
    FUNC_SCHEDULE  = 3'd5,
    FUNC_START     = 3'd6,
    FUNC_SET_SLEEP = 3'd7
  } rbs_func_e;

  // Control from the scheduler core to the sleep walker.
  typedef struct packed {
    logic                   start;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [SLEEP_WIDTH-1:0] wr_cnt;
    logic                   wr_blk;
  } rbs_sleep_req_t;

  // Status from the sleep walker back to the core.
  typedef struct packed {
    logic              done;
    logic [MASK_W-1:0] woke;
    logic [MASK_W-1:0] tmo;
  } rbs_sleep_sts_t;

  // Lowest set bit of a 32-bit mask, 0 when the mask is empty.
  // First the lowest nonzero byte is picked, then the lowest bit inside it.
  function automatic logic [PRIO_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
    logic [1:0] lane;
    logic [7:0] byte_bits;
    logic [2:0] pos;
    lane = 2'd0;
    pos  = 3'd0;
    if ((m & BYTE0_MASK) != '0) begin
      lane = 2'd0;
    end else if ((m & BYTE1_MASK) != '0) begin
      lane = 2'd1;
    end else if ((m & BYTE2_MASK) != '0) begin
      lane = 2'd2;
    end else if ((m & BYTE3_MASK) != '0) begin
      lane = 2'd3;
    end
    byte_bits = m[8*lane +: 8];
    for (int b = 7; b >= 0; b--) begin
      if (byte_bits[b]) begin
        pos = 3'(b);
      end
    end
    return {lane, pos};
  endfunction

endpackage

>>> hw/rtl/rbs_sleep_unit.sv
module rbs_sleep_unit import rbs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rbs_sleep_req_t req_i,
  output rbs_sleep_sts_t sts_o
);

  logic [SLEEP_WIDTH-1:0] cnt_q [NUM_PRIOS];
  logic [NUM_PRIOS-1:0]   blk_q;
  logic                   busy_q, busy_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [MASK_W-1:0]      woke_q, woke_d;
  logic [MASK_W-1:0]      tmo_q, tmo_d;

  logic [SLEEP_WIDTH-1:0] cnt_rd;
  logic [SLEEP_WIDTH-1:0] cnt_dec;
  logic                   skip;
  logic                   expire;
  logic [MASK_W-1:0]      idx_bit;

  // One shared decrementer works on the counter picked by the walk index.
  assign cnt_rd  = cnt_q[idx_q];
  assign cnt_dec = cnt_rd - SLEEP_WIDTH'(1);
  assign skip    = (PRIO_W'(idx_q) == IDLE_PRIO_V) || (cnt_rd == '0);
  assign expire  = busy_q && !skip && (cnt_dec == '0);
  assign idx_bit = MASK_W'(1) << idx_q;

  // Walk sequencing and wake masks.
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    woke_d = woke_q;
    tmo_d  = tmo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      woke_d = '0;
      tmo_d  = '0;
    end else if (busy_q) begin
      if (expire) begin
        woke_d = woke_q | idx_bit;
        if (blk_q[idx_q]) begin
          tmo_d = tmo_q | idx_bit;
        end
      end
      if (idx_q == LAST_IDX) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      woke_q <= '0;
      tmo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      woke_q <= woke_d;
      tmo_q  <= tmo_d;
    end
  end

  // Per-task counters and blocked flags: written by set_sleep or by the walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PRIOS; i++) begin
        cnt_q[i] <= '0;
      end
      blk_q <= '0;
    end else if (req_i.wr_en) begin
      cnt_q[req_i.wr_idx] <= req_i.wr_cnt;
      blk_q[req_i.wr_idx] <= req_i.wr_blk;
    end else if (busy_q && !skip) begin
      cnt_q[idx_q] <= cnt_dec;
      if (expire) begin
        blk_q[idx_q] <= 1'b0;
      end
    end
  end

  // Done marks the edge at which the last task is processed.
  assign sts_o.done = busy_q && (idx_q == LAST_IDX);
  assign sts_o.woke = woke_q;
  assign sts_o.tmo  = tmo_q;

endmodule

>>> hw/rtl/rtos_ready_bitmap_scheduler_unit.sv
// Priority-bitmap RTOS scheduler. Each request carries one command (ready add or
// delete, tick, interrupt enter or leave, schedule, start, set sleep) and yields
// exactly one result with the ready bitmap, highest ready priority, current
// priority, nesting depth, tick count and the wake and timeout masks of a tick.
// Every command except a tick while running is handled in the idle state, so
// such requests can be taken every cycle while the receiver takes results. A
// tick while running walks the sleep counters of all NUM_PRIOS tasks through
// one shared decrementer, one task per cycle, and holds off new requests in
// the walk and emit states until its result is loaded. The result sits in an
// output register, so a new request is taken while the previous result is
// being handed over, but not while an untaken result would have to be replaced.
module rtos_ready_bitmap_scheduler_unit import rbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [PRIO_W-1:0] prio_i,
  input  logic [STK_W-1:0]  sleep_ticks_i,
  input  logic              blocked_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PRIO_W-1:0] high_prio_o,
  output logic              high_valid_o,
  output logic              switch_request_o,
  output logic [PRIO_W-1:0] current_prio_out_o,
  output logic [NEST_W-1:0] nest_level_o,
  output logic [MASK_W-1:0] tick_count_o,
  output logic [MASK_W-1:0] ready_mask_out_o,
  output logic [MASK_W-1:0] woke_mask_o,
  output logic [MASK_W-1:0] timeout_mask_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  localparam logic [NEST_W-1:0] NEST_MAX = '1;

  state_e            state_q, state_d;
  logic [MASK_W-1:0] ready_q, ready_d;
  logic [PRIO_W-1:0] highest_q, highest_d;
  logic [PRIO_W-1:0] cur_q, cur_d;
  logic [NEST_W-1:0] nest_q, nest_d;
  logic              running_q, running_d;
  logic [MASK_W-1:0] ticks_q, ticks_d;

  logic              out_valid_q, out_valid_d;
  logic [PRIO_W-1:0] o_high_q, o_high_d;
  logic              o_hvalid_q, o_hvalid_d;
  logic              o_sw_q, o_sw_d;
  logic [MASK_W-1:0] o_woke_q, o_woke_d;
  logic [MASK_W-1:0] o_tmo_q, o_tmo_d;
  logic [PRIO_W-1:0] o_cur_q;
  logic [NEST_W-1:0] o_nest_q;
  logic [MASK_W-1:0] o_ticks_q;
  logic [MASK_W-1:0] o_ready_q;

  rbs_sleep_req_t    sleep_req;
  rbs_sleep_sts_t    sleep_sts;

  logic              out_free;
  logic              load_out;
  logic              prio_ok;
  logic [MASK_W-1:0] prio_bit;
  logic [PRIO_W-1:0] ready_enc;
  logic [PRIO_W-1:0] sched_high;
  logic              sw;

  rbs_sleep_unit u_sleep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sleep_req),
    .sts_o  (sleep_sts)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign prio_ok    = ({1'b0, prio_i} < NUM_PRIOS_CMP);
  assign prio_bit   = MASK_W'(1) << prio_i;

  // Priority that a refresh of the highest ready task would give.
  assign ready_enc  = lowest_set(ready_q);
  assign sched_high = (ready_q != '0) ? ready_enc : highest_q;

  // Command decode and sequencing.
  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    highest_d = highest_q;
    cur_d     = cur_q;
    nest_d    = nest_q;
    running_d = running_q;
    ticks_d   = ticks_q;
    sleep_req = '0;
    load_out  = 1'b0;
    sw        = 1'b0;
    o_woke_d  = '0;
    o_tmo_d   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          load_out = 1'b1;
          unique case (func_i)
            FUNC_READY_ADD: begin
              if (prio_ok) begin
                ready_d = (ready_q | prio_bit) & PRIO_MASK;
              end
            end
            FUNC_READY_DEL: begin
              if (prio_ok) begin
                ready_d = ready_q & ~prio_bit;
              end
            end
            FUNC_TICK: begin
              ticks_d = ticks_q + MASK_W'(1);
              if (running_q) begin
                load_out        = 1'b0;
                sleep_req.start = 1'b1;
                state_d         = ST_WALK;
              end
            end
            FUNC_IRQ_ENTER: begin
              if (running_q && nest_q != NEST_MAX) begin
                nest_d = nest_q + NEST_W'(1);
              end
            end
            FUNC_IRQ_LEAVE: begin
              if (running_q && nest_q != '0) begin
                nest_d = nest_q - NEST_W'(1);
                if (nest_d == '0) begin
                  highest_d = sched_high;
                  if (sched_high != cur_q) begin
                    sw    = 1'b1;
                    cur_d = sched_high;
                  end
                end
              end
            end
            FUNC_SCHEDULE: begin
              if (nest_q == '0) begin
                highest_d = sched_high;
                if (sched_high != cur_q) begin
                  sw    = 1'b1;
                  cur_d = sched_high;
                end
              end
            end
            FUNC_START: begin
              if (!running_q) begin
                highest_d = sched_high;
                cur_d     = sched_high;
                running_d = 1'b1;
              end
            end
            FUNC_SET_SLEEP: begin
              if (prio_ok) begin
                sleep_req.wr_en  = 1'b1;
                sleep_req.wr_idx = prio_i[IDX_W-1:0];
                sleep_req.wr_cnt = SLEEP_WIDTH'(sleep_ticks_i);
                sleep_req.wr_blk = blocked_i;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (sleep_sts.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ready_d  = (ready_q | sleep_sts.woke) & PRIO_MASK;
          if (sleep_sts.woke != '0) begin
            highest_d = lowest_set(ready_d);
          end
          o_woke_d = sleep_sts.woke;
          o_tmo_d  = sleep_sts.tmo;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result fields follow the state after the command.
  assign o_high_d    = lowest_set(ready_d);
  assign o_hvalid_d  = (ready_d != '0);
  assign o_sw_d      = sw;
  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Scheduler state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= '0;
      highest_q   <= '0;
      cur_q       <= '0;
      nest_q      <= '0;
      running_q   <= 1'b0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      o_high_q    <= '0;
      o_hvalid_q  <= 1'b0;
      o_sw_q      <= 1'b0;
      o_cur_q     <= '0;
      o_nest_q    <= '0;
      o_ticks_q   <= '0;
      o_ready_q   <= '0;
      o_woke_q    <= '0;
      o_tmo_q     <= '0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      highest_q   <= highest_d;
      cur_q       <= cur_d;
      nest_q      <= nest_d;
      running_q   <= running_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        o_high_q   <= o_high_d;
        o_hvalid_q <= o_hvalid_d;
        o_sw_q     <= o_sw_d;
        o_cur_q    <= cur_d;
        o_nest_q   <= nest_d;
        o_ticks_q  <= ticks_d;
        o_ready_q  <= ready_d;
        o_woke_q   <= o_woke_d;
        o_tmo_q    <= o_tmo_d;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign high_prio_o        = o_high_q;
  assign high_valid_o       = o_hvalid_q;
  assign switch_request_o   = o_sw_q;
  assign current_prio_out_o = o_cur_q;
  assign nest_level_o       = o_nest_q;
  assign tick_count_o       = o_ticks_q;
  assign ready_mask_out_o   = o_ready_q;
  assign woke_mask_o        = o_woke_q;
  assign timeout_mask_o     = o_tmo_q;

endmodule

>>> hw/rtl/rbs_checker.sv
module rbs_checker import rbs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [PRIO_W-1:0] high_prio_o,
  input logic              high_valid_o,
  input logic              switch_request_o,
  input logic [PRIO_W-1:0] current_prio_out_o,
  input logic [MASK_W-1:0] tick_count_o,
  input logic [MASK_W-1:0] ready_mask_out_o,
  input logic [MASK_W-1:0] woke_mask_o,
  input logic [MASK_W-1:0] timeout_mask_o
);

  // A woken task is always ready in the same result.
  a_woke_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((woke_mask_o & ~ready_mask_out_o) == '0))
    else $error("woken task missing from ready mask");

  // A timeout is only reported for a task that woke.
  a_tmo_woke: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((timeout_mask_o & ~woke_mask_o) == '0))
    else $error("timeout reported for a task that did not wake");

  // The reported highest priority is a ready task, and validity tracks the mask.
  a_high_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((high_valid_o == (ready_mask_out_o != '0)) &&
                     (!high_valid_o || ready_mask_out_o[high_prio_o])))
    else $error("highest ready priority inconsistent with ready mask");

  // After a switch with ready tasks, the running task is the highest one.
  a_switch_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && switch_request_o && high_valid_o) |->
      (current_prio_out_o == high_prio_o))
    else $error("switch request without current priority following");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(tick_count_o)))
    else $error("stalled result changed");

endmodule

bind rtos_ready_bitmap_scheduler_unit rbs_checker u_rbs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .high_prio_o        (high_prio_o),
  .high_valid_o       (high_valid_o),
  .switch_request_o   (switch_request_o),
  .current_prio_out_o (current_prio_out_o),
  .tick_count_o       (tick_count_o),
  .ready_mask_out_o   (ready_mask_out_o),
  .woke_mask_o        (woke_mask_o),
  .timeout_mask_o     (timeout_mask_o)
);

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 460;
  localparam int QUIET_ITEMS  = 120;
  localparam int NEST_SWEEP   = 260;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT_ITEM = 200;
  localparam int DRAIN_CYCLES = 2 * NUM_PRIOS + 8;

  // One result as the block reports it.
  typedef struct packed {
    logic [PRIO_W-1:0] high_prio;
    logic              high_valid;
    logic              switch_request;
    logic [PRIO_W-1:0] current_prio;
    logic [NEST_W-1:0] nest_level;
    logic [MASK_W-1:0] tick_count;
    logic [MASK_W-1:0] ready_mask;
    logic [MASK_W-1:0] woke_mask;
    logic [MASK_W-1:0] timeout_mask;
  } sched_result_t;

  // Tracks the scheduler state, predicts each result and checks it.
  class sched_tracker;
    logic [MASK_W-1:0]      ready_bits;
    logic [PRIO_W-1:0]      top_ready;
    logic [PRIO_W-1:0]      running_prio;
    logic [NEST_W-1:0]      depth;
    bit                     started;
    logic [MASK_W-1:0]      tick_total;
    logic [SLEEP_WIDTH-1:0] sleep_left [NUM_PRIOS];
    bit                     waits_on_resource [NUM_PRIOS];
    sched_result_t          pending_results [$];
    int unsigned            mismatches;

    function new();
      ready_bits   = '0;
      top_ready    = '0;
      running_prio = '0;
      depth        = '0;
      started      = 1'b0;
      tick_total   = '0;
      mismatches   = 0;
      foreach (sleep_left[i]) begin
        sleep_left[i]        = '0;
        waits_on_resource[i] = 1'b0;
      end
    endfunction

    // Index of the lowest set bit, zero for an empty mask.
    function logic [PRIO_W-1:0] first_ready(logic [MASK_W-1:0] m);
      logic [PRIO_W-1:0] idx;
      idx = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
        if (m[i]) begin
          idx = PRIO_W'(i);
        end
      end
      return idx;
    endfunction

    // An empty bitmap keeps the previous highest priority.
    function void refresh_top();
      if (ready_bits != '0) begin
        top_ready = first_ready(ready_bits);
      end
    endfunction

    // Scheduling only happens outside interrupts.
    function bit try_switch();
      bit sw;
      sw = 1'b0;
      if (depth == '0) begin
        refresh_top();
        if (top_ready != running_prio) begin
          sw           = 1'b1;
          running_prio = top_ready;
        end
      end
      return sw;
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_command(rbs_func_e cmd, logic [PRIO_W-1:0] prio,
                               logic [STK_W-1:0] stk, logic blk);
      sched_result_t     r;
      bit                sw;
      logic [MASK_W-1:0] woke;
      logic [MASK_W-1:0] tmo;
      sw   = 1'b0;
      woke = '0;
      tmo  = '0;
      case (cmd)
        FUNC_READY_ADD: begin
          if (int'(prio) < NUM_PRIOS) begin
            ready_bits[prio] = 1'b1;
          end
        end
        FUNC_READY_DEL: begin
          if (int'(prio) < NUM_PRIOS) begin
            ready_bits[prio] = 1'b0;
          end
        end
        FUNC_TICK: begin
          tick_total = tick_total + 1;
          // The idle task never counts down.
          if (started) begin
            for (int i = 0; i < NUM_PRIOS; i++) begin
              if (i != IDLE_PRIO && sleep_left[i] != '0) begin
                sleep_left[i] = sleep_left[i] - 1'b1;
                if (sleep_left[i] == '0) begin
                  woke[i]       = 1'b1;
                  ready_bits[i] = 1'b1;
                  if (waits_on_resource[i]) begin
                    tmo[i]               = 1'b1;
                    waits_on_resource[i] = 1'b0;
                  end
                end
              end
            end
            if (woke != '0) begin
              refresh_top();
            end
          end
        end
        FUNC_IRQ_ENTER: begin
          if (started && depth != '1) begin
            depth = depth + 1'b1;
          end
        end
        FUNC_IRQ_LEAVE: begin
          if (started && depth != '0) begin
            depth = depth - 1'b1;
            if (depth == '0) begin
              sw = try_switch();
            end
          end
        end
        FUNC_SCHEDULE: begin
          sw = try_switch();
        end
        FUNC_START: begin
          if (!started) begin
            refresh_top();
            running_prio = top_ready;
            started      = 1'b1;
          end
        end
        FUNC_SET_SLEEP: begin
          if (int'(prio) < NUM_PRIOS) begin
            sleep_left[prio]        = SLEEP_WIDTH'(stk);
            waits_on_resource[prio] = blk;
          end
        end
        default: begin
        end
      endcase
      r.high_prio      = first_ready(ready_bits);
      r.high_valid     = (ready_bits != '0);
      r.switch_request = sw;
      r.current_prio   = running_prio;
      r.nest_level     = depth;
      r.tick_count     = tick_total;
      r.ready_mask     = ready_bits;
      r.woke_mask      = woke;
      r.timeout_mask   = tmo;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [MASK_W-1:0] want,
                                logic [MASK_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Compares a delivered result with the oldest prediction.
    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                 $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("high_prio", want.high_prio, got.high_prio);
      compare_field("high_valid", want.high_valid, got.high_valid);
      compare_field("switch_request", want.switch_request, got.switch_request);
      compare_field("current_prio", want.current_prio, got.current_prio);
      compare_field("nest_level", want.nest_level, got.nest_level);
      compare_field("tick_count", want.tick_count, got.tick_count);
      compare_field("ready_mask", want.ready_mask, got.ready_mask);
      compare_field("woke_mask", want.woke_mask, got.woke_mask);
      compare_field("timeout_mask", want.timeout_mask, got.timeout_mask);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [FUNC_W-1:0] func_i = '0;
  logic [PRIO_W-1:0] prio_i = '0;
  logic [STK_W-1:0]  sleep_ticks_i = '0;
  logic              blocked_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PRIO_W-1:0] high_prio_o;
  logic              high_valid_o;
  logic              switch_request_o;
  logic [PRIO_W-1:0] current_prio_out_o;
  logic [NEST_W-1:0] nest_level_o;
  logic [MASK_W-1:0] tick_count_o;
  logic [MASK_W-1:0] ready_mask_out_o;
  logic [MASK_W-1:0] woke_mask_o;
  logic [MASK_W-1:0] timeout_mask_o;

  sched_tracker tracker;
  bit           quiet = 1'b0;
  bit           hold_request = 1'b0;
  int unsigned  cycle_count = 0;

  rtos_ready_bitmap_scheduler_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .prio_i             (prio_i),
    .sleep_ticks_i      (sleep_ticks_i),
    .blocked_i          (blocked_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .high_prio_o        (high_prio_o),
    .high_valid_o       (high_valid_o),
    .switch_request_o   (switch_request_o),
    .current_prio_out_o (current_prio_out_o),
    .nest_level_o       (nest_level_o),
    .tick_count_o       (tick_count_o),
    .ready_mask_out_o   (ready_mask_out_o),
    .woke_mask_o        (woke_mask_o),
    .timeout_mask_o     (timeout_mask_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Offers one request, with an optional idle burst first, and waits until it is taken.
  task automatic send_command(rbs_func_e cmd, logic [PRIO_W-1:0] prio,
                              logic [STK_W-1:0] stk, logic blk);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= cmd;
    prio_i        <= prio;
    sleep_ticks_i <= stk;
    blocked_i     <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_command(cmd, prio, stk, blk);
  endtask

  // Ticks and short sleeps are the most common commands, so that tasks keep waking up.
  task automatic send_random();
    int                pick;
    rbs_func_e         cmd;
    logic [STK_W-1:0]  stk;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      stk = STK_W'($urandom);
    end else begin
      stk = STK_W'($urandom_range(0, 6));
    end
    if (pick < 28) begin
      cmd = FUNC_TICK;
    end else if (pick < 46) begin
      cmd = FUNC_SET_SLEEP;
    end else if (pick < 60) begin
      cmd = FUNC_READY_ADD;
    end else if (pick < 70) begin
      cmd = FUNC_READY_DEL;
    end else if (pick < 80) begin
      cmd = FUNC_SCHEDULE;
    end else if (pick < 88) begin
      cmd = FUNC_IRQ_ENTER;
    end else if (pick < 97) begin
      cmd = FUNC_IRQ_LEAVE;
    end else begin
      cmd = FUNC_START;
    end
    send_command(cmd, PRIO_W'($urandom), stk, 1'($urandom));
  endtask

  // Result side: checks every delivered result and stalls in random bursts.
  initial begin : result_sink
    int            stall_left;
    sched_result_t got;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{high_prio_o, high_valid_o, switch_request_o, current_prio_out_o,
                nest_level_o, tick_count_o, ready_mask_out_o, woke_mask_o,
                timeout_mask_o};
        tracker.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before start: schedule on an empty bitmap; a tick only counts, and interrupts are ignored.
    send_command(FUNC_SCHEDULE, '0, '0, 1'b0);
    send_command(FUNC_TICK, '0, '0, 1'b0);
    send_command(FUNC_IRQ_ENTER, '0, '0, 1'b0);
    send_command(FUNC_IRQ_LEAVE, '0, '0, 1'b0);
    send_command(FUNC_READY_ADD, 5'd31, '0, 1'b0);
    send_command(FUNC_READY_ADD, 5'd0, '0, 1'b0);
    send_command(FUNC_READY_DEL, 5'd0, '0, 1'b0);
    send_command(FUNC_READY_ADD, 5'd5, '0, 1'b0);
    // Sleeps: the idle task, a blocked waiter, a plain sleeper, a cancel and the maximum.
    send_command(FUNC_SET_SLEEP, 5'd31, 16'd1, 1'b1);
    send_command(FUNC_SET_SLEEP, 5'd3, 16'd1, 1'b1);
    send_command(FUNC_SET_SLEEP, 5'd4, 16'd2, 1'b0);
    send_command(FUNC_SET_SLEEP, 5'd6, 16'd3, 1'b0);
    send_command(FUNC_SET_SLEEP, 5'd6, 16'd0, 1'b0);
    send_command(FUNC_SET_SLEEP, 5'd0, 16'hffff, 1'b1);
    send_command(FUNC_START, '0, '0, 1'b0);
    send_command(FUNC_START, '0, '0, 1'b0);
    send_command(FUNC_TICK, '1, '1, 1'b1);
    send_command(FUNC_TICK, '0, '0, 1'b0);
    // Schedule inside an interrupt is held back until the last leave.
    send_command(FUNC_IRQ_ENTER, '0, '0, 1'b0);
    send_command(FUNC_SCHEDULE, '0, '0, 1'b0);
    send_command(FUNC_READY_DEL, 5'd3, '0, 1'b0);
    send_command(FUNC_IRQ_LEAVE, '0, '0, 1'b0);
    send_command(FUNC_IRQ_LEAVE, '0, '0, 1'b0);
    // Empty the bitmap, then schedule keeps the old highest priority.
    send_command(FUNC_READY_DEL, 5'd4, '0, 1'b0);
    send_command(FUNC_READY_DEL, 5'd5, '0, 1'b0);
    send_command(FUNC_READY_DEL, 5'd31, '0, 1'b0);
    send_command(FUNC_SCHEDULE, '0, '0, 1'b0);

    // Nest past saturation and back down to zero.
    repeat (NEST_SWEEP) begin
      send_command(FUNC_IRQ_ENTER, PRIO_W'($urandom), STK_W'($urandom), 1'($urandom));
    end
    send_command(FUNC_SCHEDULE, '0, '0, 1'b0);
    repeat (NEST_SWEEP) begin
      send_command(FUNC_IRQ_LEAVE, PRIO_W'($urandom), STK_W'($urandom), 1'($urandom));
    end

    // Random mix, one long receiver hold-off, and a final stretch without idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT_ITEM) begin
        hold_request = 1'b1;
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      send_random();
    end
    in_valid_i <= 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_sleep_unit.sv
hw/rtl/rtos_ready_bitmap_scheduler_unit.sv
hw/rtl/rbs_checker.sv
test/testbench.sv
